// File: sv/mptw_pkg.sv
// mptw_pkg: shared types and constants for the page table walker
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package mptw_pkg;

	// fixed field widths of the request and response beats
	localparam int VA_W     = 48;
	localparam int PA_W     = 18;
	localparam int STATUS_W = 2;

	// response status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOFRAME  = 2'd2;

	// operation decoded by the front end
	typedef enum logic {
		OP_TRANSLATE = 1'b0,
		OP_ALLOCATE  = 1'b1
	} op_t;

	// classified command held in the queue
	typedef struct packed {
		op_t             op;
		logic [VA_W-1:0] va;
	} cmd_t;

	// command beat between front, queue and back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

	// walker sequencer states
	typedef enum logic [1:0] {
		WALK_CLEAR,
		WALK_IDLE,
		WALK_READ,
		WALK_CHECK
	} walk_state_t;

endpackage

// File: sv/mptw_req_if.sv
// mptw_req_if: request channel carrying mode and virtual address
// depends on mptw_pkg
`timescale 1ns / 1ps

interface mptw_req_if
	import mptw_pkg::*;
();
	logic            valid;
	logic            ready;
	logic            mode;
	logic [VA_W-1:0] virt_addr;

	modport source (output valid, output mode, output virt_addr, input ready);
	modport sink   (input valid, input mode, input virt_addr, output ready);
endinterface

// File: sv/mptw_rsp_if.sv
// mptw_rsp_if: response channel carrying physical address and status
// depends on mptw_pkg
`timescale 1ns / 1ps

interface mptw_rsp_if
	import mptw_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [PA_W-1:0]     phys_addr;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output phys_addr, output status, input ready);
	modport sink   (input valid, input phys_addr, input status, output ready);
endinterface

// File: sv/multilevel_page_table_walker_top.sv
// path: a beat accepted on req goes through the command queue, the idle state, a read and
// a check state per level and the result register; a walk ends early on a missing root,
// entry or frame. throughput: a new walk starts only after the previous one is back in
// idle, as each level needs a dependent table store read; two further beats wait in the queue
// reset: asynchronous, then a clearing pass over all FRAME_COUNT << (PAGE_OFFSET_BITS-3)
// entries (32768 at defaults) of the table store with req.ready low
`timescale 1ns / 1ps

module multilevel_page_table_walker_top
	import mptw_pkg::*;
#(
	parameter int PAGE_OFFSET_BITS = 12,
	parameter int LEVEL_COUNT      = 4,
	parameter int FRAME_COUNT      = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	mptw_req_if.sink   req,
	mptw_rsp_if.source rsp
);

	cmd_beat_t push;
	cmd_beat_t pop;
	logic      push_ready;
	logic      cmd_pop;
	logic      clear_done;

	// accept and classify
	mptw_front u_front (
		.req        (req),
		.clear_done (clear_done),
		.push_ready (push_ready),
		.push       (push)
	);

	// decoupling queue
	mptw_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (cmd_pop)
	);

	// walk and respond
	mptw_back #(
		.PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
		.LEVEL_COUNT      (LEVEL_COUNT),
		.FRAME_COUNT      (FRAME_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (pop),
		.cmd_pop    (cmd_pop),
		.clear_done (clear_done),
		.rsp        (rsp)
	);

	// no request beat is taken during the clearing pass
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done |-> !req.ready)
		else $error("request accepted during table clear");

	// queue is still empty when the clearing pass finishes
	a_queue_empty_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(clear_done) |-> !pop.valid)
		else $error("command queued during table clear");

	// a failed walk reports address zero
	a_error_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STATUS_OK) |-> (rsp.phys_addr == '0))
		else $error("nonzero address on error response");

	// commands leave the queue only when the back end pops a valid head
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (pop.valid && clear_done))
		else $error("pop without a queued command");

endmodule

// File: sv/mptw_front.sv
// mptw_front: accepts request beats and classifies them into queue commands
// depends on mptw_pkg and mptw_req_if
`timescale 1ns / 1ps

module mptw_front
	import mptw_pkg::*;
(
	mptw_req_if.sink  req,
	input  logic      clear_done,
	input  logic      push_ready,
	output cmd_beat_t push
);

	// hold requests off while the table store is being cleared
	assign req.ready = clear_done & push_ready;

	// decode the request into a command for the back end
	always_comb begin
		push.valid   = req.valid & clear_done;
		push.cmd.op  = req.mode ? OP_ALLOCATE : OP_TRANSLATE;
		push.cmd.va  = req.virt_addr;
	end

endmodule

// File: sv/mptw_cmd_fifo.sv
// mptw_cmd_fifo: two-entry command queue between front and back end
// depends on mptw_pkg
`timescale 1ns / 1ps

module mptw_cmd_fifo
	import mptw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_beat_t push,
	output logic      push_ready,
	output cmd_beat_t pop,
	input  logic      pop_ready
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign do_push    = push.valid & push_ready;
	assign do_pop     = pop.valid & pop_ready;

	// head of the queue
	always_comb begin
		pop.valid = (count_q != 2'd0);
		pop.cmd   = slot_q[rd_ptr_q];
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push.cmd;
	end

endmodule

// File: sv/mptw_back.sv
// mptw_back: table walk sequencer with the internal frame store and result register
// depends on mptw_pkg and mptw_rsp_if
`timescale 1ns / 1ps

module mptw_back
	import mptw_pkg::*;
#(
	parameter int PAGE_OFFSET_BITS = 12,
	parameter int LEVEL_COUNT      = 4,
	parameter int FRAME_COUNT      = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_beat_t cmd,
	output logic      cmd_pop,
	output logic      clear_done,
	mptw_rsp_if.source rsp
);

	localparam int IDX_BITS = PAGE_OFFSET_BITS - 3;
	localparam int FB       = $clog2(FRAME_COUNT);
	localparam int EW       = FB + 1;
	localparam int AW       = FB + IDX_BITS;
	localparam int DEPTH    = FRAME_COUNT << IDX_BITS;
	localparam int NFW      = $clog2(FRAME_COUNT + 1);
	localparam int LVW      = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
	localparam int VEW      = VA_W + PAGE_OFFSET_BITS + IDX_BITS * LEVEL_COUNT;
	localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [NFW-1:0] NF_FULL   = NFW'(FRAME_COUNT);
	localparam logic [LVW-1:0] LAST_LVL  = LVW'(LEVEL_COUNT - 1);

	// table store: bit 0 valid, upper bits frame index
	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rdata_q;

	walk_state_t     state_q, state_d;
	logic [AW-1:0]   clr_q, clr_d;
	logic [LVW-1:0]  lvl_q, lvl_d;
	logic [FB-1:0]   frame_q, frame_d;
	logic [NFW-1:0]  next_free_q, next_free_d;
	logic            root_q, root_d;
	logic [VA_W-1:0] va_q, va_d;
	op_t             op_q, op_d;

	logic                rsp_valid_q;
	logic [PA_W-1:0]     phys_q;
	logic [STATUS_W-1:0] status_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [EW-1:0]       mem_wdata;
	logic [AW-1:0]       walk_addr;
	logic                res_load;
	logic [PA_W-1:0]     res_phys;
	logic [STATUS_W-1:0] res_status;
	logic                out_free;
	logic [FB-1:0]       nf_frame;
	logic [FB-1:0]       adv_frame;
	logic [PA_W+FB+PAGE_OFFSET_BITS-1:0] phys_ext;
	logic [VEW-1:0]      va_ext;
	logic [IDX_BITS-1:0] idx_arr [LEVEL_COUNT];

	// per-level index slices, most significant level first
	assign va_ext = VEW'(va_q);
	for (genvar l = 0; l < LEVEL_COUNT; l++) begin : g_idx
		localparam int SH = PAGE_OFFSET_BITS + IDX_BITS * (LEVEL_COUNT - 1 - l);
		assign idx_arr[l] = va_ext[SH +: IDX_BITS];
	end

	assign walk_addr = {frame_q, idx_arr[lvl_q]};
	assign nf_frame  = next_free_q[FB-1:0];
	assign out_free  = !rsp_valid_q || rsp.ready;

	// frame the walk moves to: existing entry or a freshly taken frame
	assign adv_frame = rdata_q[0] ? rdata_q[EW-1:1] : nf_frame;
	assign phys_ext  = {{PA_W{1'b0}}, adv_frame, va_q[PAGE_OFFSET_BITS-1:0]};
	assign res_phys  = phys_ext[PA_W-1:0];

	assign clear_done = (state_q != WALK_CLEAR);

	// sequencer state register and walk context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= WALK_CLEAR;
			clr_q       <= '0;
			lvl_q       <= '0;
			frame_q     <= '0;
			next_free_q <= '0;
			root_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			lvl_q       <= lvl_d;
			frame_q     <= frame_d;
			next_free_q <= next_free_d;
			root_q      <= root_d;
		end
	end

	// command payload of the walk in progress
	always_ff @(posedge clk) begin
		va_q <= va_d;
		op_q <= op_d;
	end

	// next state, memory writes and result loading
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		lvl_d       = lvl_q;
		frame_d     = frame_q;
		next_free_d = next_free_q;
		root_d      = root_q;
		va_d        = va_q;
		op_d        = op_q;
		mem_we      = 1'b0;
		mem_waddr   = walk_addr;
		mem_wdata   = '0;
		res_load    = 1'b0;
		res_status  = STATUS_OK;
		cmd_pop     = 1'b0;
		case (state_q)
			WALK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + AW'(1);
				if (clr_q == LAST_ADDR)
					state_d = WALK_IDLE;
			end
			WALK_IDLE: begin
				if (cmd.valid && out_free) begin
					cmd_pop = 1'b1;
					va_d    = cmd.cmd.va;
					op_d    = cmd.cmd.op;
					lvl_d   = '0;
					if (root_q) begin
						frame_d = '0;
						state_d = WALK_READ;
					end else if (cmd.cmd.op == OP_TRANSLATE) begin
						res_load   = 1'b1;
						res_status = STATUS_UNMAPPED;
					end else if (next_free_q == NF_FULL) begin
						res_load   = 1'b1;
						res_status = STATUS_NOFRAME;
					end else begin
						root_d      = 1'b1;
						frame_d     = nf_frame;
						next_free_d = next_free_q + NFW'(1);
						state_d     = WALK_READ;
					end
				end
			end
			WALK_READ: begin
				state_d = WALK_CHECK;
			end
			WALK_CHECK: begin
				if (!rdata_q[0] && op_q == OP_TRANSLATE) begin
					res_load   = 1'b1;
					res_status = STATUS_UNMAPPED;
					state_d    = WALK_IDLE;
				end else if (!rdata_q[0] && next_free_q == NF_FULL) begin
					res_load   = 1'b1;
					res_status = STATUS_NOFRAME;
					state_d    = WALK_IDLE;
				end else begin
					// missing entry on an allocate: link a fresh frame
					if (!rdata_q[0]) begin
						mem_we      = 1'b1;
						mem_wdata   = {nf_frame, 1'b1};
						next_free_d = next_free_q + NFW'(1);
					end
					frame_d = adv_frame;
					if (lvl_q == LAST_LVL) begin
						res_load   = 1'b1;
						res_status = STATUS_OK;
						state_d    = WALK_IDLE;
					end else begin
						lvl_d   = lvl_q + LVW'(1);
						state_d = WALK_READ;
					end
				end
			end
			default: begin
				state_d = WALK_IDLE;
			end
		endcase
	end

	// table store ports
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[walk_addr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (res_load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			phys_q   <= (res_status == STATUS_OK) ? res_phys : '0;
			status_q <= res_status;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.phys_addr = phys_q;
	assign rsp.status    = status_q;

endmodule

// File: tb/multilevel_page_table_walker_top_tb.sv
// multilevel_page_table_walker_top_tb: self-checking bench for the page table walker
// drives translate and allocate requests, predicts each response from a private copy of
// the table store; depends on mptw_pkg, mptw_req_if, mptw_rsp_if and the walker top
`timescale 1ns / 1ps

module multilevel_page_table_walker_top_tb;
	import mptw_pkg::*;

	localparam int PAGE_OFFSET_BITS = 12;
	localparam int LEVEL_COUNT      = 4;
	localparam int FRAME_COUNT      = 64;
	localparam int IDX_BITS         = PAGE_OFFSET_BITS - 3;
	localparam int STORE_DEPTH      = FRAME_COUNT << IDX_BITS;
	localparam int FRAME_W          = $clog2(FRAME_COUNT);

	localparam int RANDOM_REQS    = 700;
	localparam int IDLE_PCT       = 11;
	localparam int CALM_FROM      = 300;
	localparam int CALM_TO        = 450;
	localparam int REPORT_MAX     = 10;
	// clearing pass after reset plus generous headroom for stalls
	localparam int WATCHDOG_LIMIT = 3 * STORE_DEPTH + 4096;
	localparam int TAIL_CYCLES    = 2 * LEVEL_COUNT + 10;

	typedef struct {
		op_t             op;
		logic [VA_W-1:0] va;
	} walk_req_t;

	typedef struct packed {
		logic [PA_W-1:0]     phys_addr;
		logic [STATUS_W-1:0] status;
	} walk_rsp_t;

	logic clk;
	logic arst_n;

	mptw_req_if req_ch ();
	mptw_rsp_if rsp_ch ();

	multilevel_page_table_walker_top #(
		.PAGE_OFFSET_BITS(PAGE_OFFSET_BITS),
		.LEVEL_COUNT     (LEVEL_COUNT),
		.FRAME_COUNT     (FRAME_COUNT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// private copy of the walker state
	bit                pte_valid [STORE_DEPTH];
	bit [FRAME_W-1:0]  pte_frame [STORE_DEPTH];
	bit                root_built;
	int unsigned       frames_used;

	walk_req_t         pending_reqs[$];
	walk_rsp_t         expected_rsps[$];
	logic [VA_W-1:0]   alloc_pool[$];

	int req_beats;
	int rsp_beats;
	int total_reqs;
	int mismatches;
	int stall_cycles;
	int n_translate;
	int n_allocate;
	int n_ok;
	int n_unmapped;
	int n_noframe;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// index of one level taken from the virtual address, top level first
	function automatic int unsigned level_slice(logic [VA_W-1:0] va, int lvl);
		int         shift;
		logic [63:0] wide;
		shift = PAGE_OFFSET_BITS + IDX_BITS * (LEVEL_COUNT - 1 - lvl);
		if (shift >= 64)
			return 0;
		wide = 64'(va) >> shift;
		return int'(wide & ((64'd1 << IDX_BITS) - 64'd1));
	endfunction

	function automatic int unsigned slot_index(int unsigned frame, int unsigned idx);
		return ((frame << IDX_BITS) | idx) % STORE_DEPTH;
	endfunction

	// walk the predicted tables, filling holes on allocate
	function automatic walk_rsp_t predict_walk(op_t op, logic [VA_W-1:0] va);
		walk_rsp_t   r;
		int unsigned frame;
		int unsigned slot;
		logic [63:0] pa;
		r.phys_addr = '0;
		r.status    = STATUS_UNMAPPED;
		frame       = 0;
		if (op == OP_TRANSLATE) begin
			if (!root_built)
				return r;
			for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
				slot = slot_index(frame, level_slice(va, lvl));
				if (!pte_valid[slot])
					return r;
				frame = pte_frame[slot];
			end
		end else begin
			if (!root_built) begin
				if (frames_used >= FRAME_COUNT) begin
					r.status = STATUS_NOFRAME;
					return r;
				end
				root_built  = 1'b1;
				frame       = frames_used;
				frames_used = frames_used + 1;
			end
			for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
				slot = slot_index(frame, level_slice(va, lvl));
				if (!pte_valid[slot]) begin
					// entries written so far stay, the walk just stops here
					if (frames_used >= FRAME_COUNT) begin
						r.status = STATUS_NOFRAME;
						return r;
					end
					pte_valid[slot] = 1'b1;
					pte_frame[slot] = FRAME_W'(frames_used);
					frames_used     = frames_used + 1;
				end
				frame = pte_frame[slot];
			end
		end
		pa = (64'(frame) << PAGE_OFFSET_BITS)
			| (64'(va) & ((64'd1 << PAGE_OFFSET_BITS) - 64'd1));
		r.phys_addr = pa[PA_W-1:0];
		r.status    = STATUS_OK;
		return r;
	endfunction

	function automatic logic [VA_W-1:0] rand_va();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[VA_W-1:0];
	endfunction

	// keep the upper levels of base, randomise the lowest k levels and the offset
	function automatic logic [VA_W-1:0] reslice(logic [VA_W-1:0] base, int k);
		logic [63:0] mask;
		mask = (64'd1 << (PAGE_OFFSET_BITS + IDX_BITS * k)) - 64'd1;
		return (base & ~mask[VA_W-1:0]) | (rand_va() & mask[VA_W-1:0]);
	endfunction

	function automatic logic [VA_W-1:0] pool_pick();
		return alloc_pool[$urandom_range(0, alloc_pool.size() - 1)];
	endfunction

	task automatic push_req(op_t op, logic [VA_W-1:0] va);
		walk_req_t it;
		it.op = op;
		it.va = va;
		pending_reqs.push_back(it);
		if (op == OP_ALLOCATE)
			alloc_pool.push_back(va);
	endtask

	// request driver: holds a beat until accepted, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		walk_req_t it;
		bit        calm;
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.mode      <= 1'b0;
			req_ch.virt_addr <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_rsps.push_back(predict_walk(op_t'(req_ch.mode), req_ch.virt_addr));
				if (op_t'(req_ch.mode) == OP_TRANSLATE)
					n_translate++;
				else
					n_allocate++;
				req_beats++;
			end
			calm = (req_beats >= CALM_FROM) && (req_beats < CALM_TO);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					it = pending_reqs.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.mode      <= it.op;
					req_ch.virt_addr <= it.va;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor: checks each beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		walk_rsp_t want;
		bit        calm;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_beats++;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("[%0t] unexpected response: phys_addr %h status %0d",
							$realtime, rsp_ch.phys_addr, rsp_ch.status);
				end else begin
					want = expected_rsps.pop_front();
					case (want.status)
						STATUS_OK:       n_ok++;
						STATUS_UNMAPPED: n_unmapped++;
						default:         n_noframe++;
					endcase
					if (rsp_ch.phys_addr !== want.phys_addr || rsp_ch.status !== want.status) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("[%0t] response %0d: phys_addr %h status %0d, expected %h status %0d",
								$realtime, rsp_beats, rsp_ch.phys_addr, rsp_ch.status,
								want.phys_addr, want.status);
					end
				end
			end
			calm = (rsp_beats >= CALM_FROM) && (rsp_beats < CALM_TO);
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", stall_cycles);
			$display("multilevel_page_table_walker_top test failed");
			$finish;
		end
	end

	initial begin
		int pick;
		int w;
		int k;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.mode      = 1'b0;
		req_ch.virt_addr = '0;
		rsp_ch.ready     = 1'b0;
		root_built       = 1'b0;
		frames_used      = 0;
		req_beats        = 0;
		rsp_beats        = 0;
		mismatches       = 0;
		stall_cycles     = 0;
		n_translate      = 0;
		n_allocate       = 0;
		n_ok             = 0;
		n_unmapped       = 0;
		n_noframe        = 0;

		// directed: no root, first allocation, extremes, remapping, misses at each depth
		push_req(OP_TRANSLATE, '0);
		push_req(OP_TRANSLATE, '1);
		push_req(OP_ALLOCATE,  '0);
		push_req(OP_TRANSLATE, '0);
		push_req(OP_TRANSLATE, 48'h0000_0000_0FFF);
		push_req(OP_ALLOCATE,  48'h0000_0000_0ABC);
		push_req(OP_ALLOCATE,  '1);
		push_req(OP_TRANSLATE, '1);
		push_req(OP_TRANSLATE, 48'h0000_0000_1000);
		push_req(OP_TRANSLATE, 48'h0080_0000_0000);
		push_req(OP_ALLOCATE,  48'h0000_0000_1000);
		push_req(OP_TRANSLATE, 48'h0000_0000_1ABC);
		push_req(OP_TRANSLATE, 48'hAAAA_AAAA_AAAA);
		push_req(OP_ALLOCATE,  48'h5555_5555_5555);
		push_req(OP_TRANSLATE, 48'h5555_5555_5555);
		push_req(OP_TRANSLATE, 48'h5555_5555_4555);
		push_req(OP_TRANSLATE, 48'h5555_5540_0555);
		push_req(OP_ALLOCATE,  48'h7FFF_FFFF_F000);
		push_req(OP_TRANSLATE, 48'h7FFF_FFFF_FFFF);

		// random: mostly paths that share prefixes so the frames last, runs into exhaustion
		for (int n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(0, 99);
			w    = $urandom_range(0, 99);
			k    = (w < 40) ? 0 : (w < 75) ? 1 : (w < 90) ? 2 : (w < 97) ? 3 : LEVEL_COUNT;
			if (pick < 35)
				push_req(OP_TRANSLATE, reslice(pool_pick(), 0));
			else if (pick < 52)
				push_req(OP_ALLOCATE, reslice(pool_pick(), k));
			else if (pick < 55)
				push_req(OP_ALLOCATE, rand_va());
			else if (pick < 70)
				push_req(OP_TRANSLATE, reslice(pool_pick(), $urandom_range(1, LEVEL_COUNT)));
			else if (pick < 88)
				push_req(OP_TRANSLATE, rand_va());
			else
				push_req(OP_TRANSLATE, reslice(pool_pick(), k));
		end
		total_reqs = pending_reqs.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every request accepted and every response seen
		while (req_beats < total_reqs || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rsps.size() != 0)
			mismatches++;

		$display("covered %0d requests (%0d translate, %0d allocate), %0d frames used",
			req_beats, n_translate, n_allocate, frames_used);
		$display("responses: %0d ok, %0d unmapped, %0d out of frames, %0d mismatches",
			n_ok, n_unmapped, n_noframe, mismatches);
		if (mismatches == 0)
			$display("multilevel_page_table_walker_top test passed");
		else
			$display("multilevel_page_table_walker_top test failed");
		$finish;
	end

endmodule
